### src/statement_stream_decoder_assert.svh
// Assertion macros for the statement stream decoder checker.
`ifndef STATEMENT_STREAM_DECODER_ASSERT_SVH
`define STATEMENT_STREAM_DECODER_ASSERT_SVH

// Same-cycle implication, clocked on i_clk, off while reset is held.
`define SSD_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("statement stream decoder check failed");

// Next-cycle implication, clocked on i_clk, off while reset is held.
`define SSD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("statement stream decoder check failed");

`endif

### src/ssd_pkg.sv
// Types and constants of the statement stream decoder.
package ssd_pkg;

    localparam int ID_W     = 21;
    localparam int CNT_W    = 22;
    localparam int CLASS_W  = 4;
    localparam int TYPE_W   = 12;
    localparam int KIND_W   = 3;
    localparam int ERR_W    = 2;
    localparam int BYTE_W   = 8;
    localparam int CFG_IDX_W = 2;

    localparam logic [BYTE_W-1:0]  TERM_BYTE      = 8'hFF;
    localparam logic [CLASS_W-1:0] MAX_CLASS_INIT = 4'hF;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ID_COUNT  = 2'd0,
        CFG_MAX_CLASS = 2'd1
    } t_cfg_reg;

    typedef enum logic [2:0] {
        PH_HDR0 = 3'd0,
        PH_HDR1 = 3'd1,
        PH_INST = 3'd2,
        PH_IO   = 3'd3,
        PH_ATTR = 3'd4
    } t_phase;

    typedef enum logic [KIND_W-1:0] {
        KIND_HEADER = 3'd0,
        KIND_INST   = 3'd1,
        KIND_IO     = 3'd2,
        KIND_ATTR   = 3'd3,
        KIND_END    = 3'd4,
        KIND_ERROR  = 3'd5
    } t_kind;

    typedef enum logic [ERR_W-1:0] {
        ERR_BAD_CLASS = 2'd0,
        ERR_RANGE     = 2'd1,
        ERR_TWO_LEFT  = 2'd2,
        ERR_DANGLING  = 2'd3
    } t_err;

    typedef struct packed {
        t_kind              kind;
        logic [CLASS_W-1:0] stmt_class;
        logic [TYPE_W-1:0]  stmt_type;
        logic               present;
        logic               input_flag;
        logic [ID_W-1:0]    first_index;
        logic [ID_W-1:0]    second_index;
        t_err               error_code;
    } t_result;

endpackage

### src/statement_stream_decoder.sv
// Statement stream decoder: byte-serial netlist statement parser with result register.
//
// Input channel: one stream byte per beat on i_stream_byte, taken at an edge with
// i_in_valid high and o_in_stall low. Output channel: one result beat (header,
// instance, io entry, attribute entry, statement end or error) on the o_ fields,
// taken at an edge with o_out_valid high and i_out_stall low. Many bytes give no
// result at all (first and second bytes of a long id, non-last pair sides, io terminator).
// Configuration: i_cfg_valid/o_cfg_ready write i_cfg_data to register i_cfg_index
// (0 id_count, 1 max_class); o_cfg_ready is always high, other indices are dropped.
// Timing: one byte per cycle while no result waits under i_out_stall. A result
// appears on the output in the cycle after its byte is taken; the decode of a byte
// is a single pass of logic in front of the result register.
// Stall: while a result waits under i_out_stall, o_in_stall is raised and input
// holds; a byte is still taken in the cycle the waiting result leaves.
// Reset (i_rst_n low, synchronous): expect a header byte, clear pending pair and
// error, id_count to zero, max_class to 15, output empty.
// After any error result, every later byte is taken and dropped until reset.
module statement_stream_decoder (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [ssd_pkg::BYTE_W-1:0]    i_stream_byte,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [ssd_pkg::KIND_W-1:0]    o_kind,
    output logic [ssd_pkg::CLASS_W-1:0]   o_stmt_class,
    output logic [ssd_pkg::TYPE_W-1:0]    o_stmt_type,
    output logic                          o_present,
    output logic                          o_input_flag,
    output logic [ssd_pkg::ID_W-1:0]      o_first_index,
    output logic [ssd_pkg::ID_W-1:0]      o_second_index,
    output logic [ssd_pkg::ERR_W-1:0]     o_error_code,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [ssd_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [ssd_pkg::CNT_W-1:0]     i_cfg_data
);
    import ssd_pkg::*;

    // configuration
    logic [CNT_W-1:0]   r_id_count;
    logic [CLASS_W-1:0] r_max_class;

    // parser state
    t_phase             r_phase,        n_phase;
    logic [1:0]         r_ext_left,     n_ext_left;
    logic [ID_W-1:0]    r_accum,        n_accum;
    logic [1:0]         r_flags,        n_flags;
    logic [CLASS_W-1:0] r_class_hold,   n_class_hold;
    logic [ID_W-1:0]    r_pend_left,    n_pend_left;
    logic               r_pend_valid,   n_pend_valid;
    logic               r_err_latched,  n_err_latched;

    // result register
    logic               r_out_valid,    n_out_valid;
    t_result            r_res,          n_res;

    logic               in_take;
    logic               out_take;
    logic               emit;
    logic               first_byte;
    logic               do_finish;
    logic [ID_W-1:0]    id_val;
    logic [BYTE_W-1:0]  b;

    assign b           = i_stream_byte;
    assign o_in_stall  = r_out_valid && i_out_stall;
    assign in_take     = i_in_valid && !o_in_stall;
    assign out_take    = r_out_valid && !i_out_stall;
    assign o_cfg_ready = 1'b1;

    always_comb begin
        n_phase       = r_phase;
        n_ext_left    = r_ext_left;
        n_accum       = r_accum;
        n_flags       = r_flags;
        n_class_hold  = r_class_hold;
        n_pend_left   = r_pend_left;
        n_pend_valid  = r_pend_valid;
        n_err_latched = r_err_latched;
        n_res         = '0;
        emit          = 1'b0;
        first_byte    = 1'b0;
        do_finish     = 1'b0;
        id_val        = '0;

        if (in_take && !r_err_latched) begin
            if (r_ext_left != 2'd0) begin
                // extension bytes: any value is index data
                if (r_ext_left == 2'd2) begin
                    n_accum    = r_accum | {{(ID_W-BYTE_W-5){1'b0}}, b, 5'b0};
                    n_ext_left = 2'd1;
                end else begin
                    id_val     = r_accum | {b, {(ID_W-BYTE_W){1'b0}}};
                    n_accum    = id_val;
                    n_ext_left = 2'd0;
                    do_finish  = 1'b1;
                end
            end else begin
                unique case (r_phase) inside
                    PH_HDR1: begin
                        n_res.kind       = KIND_HEADER;
                        n_res.stmt_class = r_class_hold;
                        n_res.stmt_type  = {b, r_accum[3:0]};
                        n_accum          = '0;
                        n_phase          = PH_INST;
                        emit             = 1'b1;
                    end
                    PH_INST: begin
                        if (b == TERM_BYTE) begin
                            n_res.kind = KIND_INST;
                            n_phase    = PH_IO;
                            emit       = 1'b1;
                        end else begin
                            first_byte = 1'b1;
                        end
                    end
                    PH_IO, PH_ATTR: begin
                        if (b == TERM_BYTE) begin
                            if (r_pend_valid) begin
                                n_res.kind       = KIND_ERROR;
                                n_res.error_code = ERR_DANGLING;
                                n_err_latched    = 1'b1;
                                emit             = 1'b1;
                            end else if (r_phase == PH_IO) begin
                                n_phase = PH_ATTR;
                            end else begin
                                n_res.kind = KIND_END;
                                n_phase    = PH_HDR0;
                                emit       = 1'b1;
                            end
                        end else begin
                            n_flags    = b[2:1];
                            first_byte = 1'b1;
                        end
                    end
                    default: begin
                        // header byte 0; unknown phase codes land here too
                        n_phase      = PH_HDR0;
                        n_class_hold = b[7:4];
                        if (b[7:4] > r_max_class) begin
                            n_res.kind       = KIND_ERROR;
                            n_res.error_code = ERR_BAD_CLASS;
                            n_err_latched    = 1'b1;
                            emit             = 1'b1;
                        end else begin
                            n_accum = {{(ID_W-4){1'b0}}, b[3:0]};
                            n_phase = PH_HDR1;
                        end
                    end
                endcase

                // first byte of an id: low five index bits, bit 0 marks a short id
                if (first_byte) begin
                    n_accum = {{(ID_W-5){1'b0}}, b[7:3]};
                    if (!b[0]) begin
                        n_ext_left = 2'd2;
                    end else begin
                        id_val    = {{(ID_W-5){1'b0}}, b[7:3]};
                        do_finish = 1'b1;
                    end
                end
            end

            // a complete id: range check, then instance, pair side or entry
            if (do_finish) begin
                if ({1'b0, id_val} >= r_id_count) begin
                    n_res.kind       = KIND_ERROR;
                    n_res.error_code = ERR_RANGE;
                    n_err_latched    = 1'b1;
                    emit             = 1'b1;
                end else if (r_phase == PH_INST) begin
                    n_res.kind        = KIND_INST;
                    n_res.present     = 1'b1;
                    n_res.first_index = id_val;
                    n_phase           = PH_IO;
                    emit              = 1'b1;
                end else if (!n_flags[1]) begin
                    if (r_pend_valid) begin
                        n_res.kind       = KIND_ERROR;
                        n_res.error_code = ERR_TWO_LEFT;
                        n_err_latched    = 1'b1;
                        emit             = 1'b1;
                    end else begin
                        // hold as left side of a pair
                        n_pend_left  = id_val;
                        n_pend_valid = 1'b1;
                    end
                end else begin
                    n_res.kind       = (r_phase == PH_IO) ? KIND_IO : KIND_ATTR;
                    n_res.input_flag = n_flags[0];
                    if (r_pend_valid) begin
                        n_res.present      = 1'b1;
                        n_res.first_index  = r_pend_left;
                        n_res.second_index = id_val;
                        n_pend_valid       = 1'b0;
                        n_pend_left        = '0;
                    end else begin
                        n_res.first_index = id_val;
                    end
                    emit = 1'b1;
                end
            end
        end

        // load a new result, else drop the old one once it is taken
        if (emit) begin
            n_out_valid = 1'b1;
        end else if (out_take) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_id_count    <= '0;
            r_max_class   <= MAX_CLASS_INIT;
            r_phase       <= PH_HDR0;
            r_ext_left    <= 2'd0;
            r_accum       <= '0;
            r_flags       <= 2'd0;
            r_class_hold  <= '0;
            r_pend_left   <= '0;
            r_pend_valid  <= 1'b0;
            r_err_latched <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_ID_COUNT:  r_id_count  <= i_cfg_data;
                    CFG_MAX_CLASS: r_max_class <= i_cfg_data[CLASS_W-1:0];
                    default:       ;
                endcase
            end
            r_phase       <= n_phase;
            r_ext_left    <= n_ext_left;
            r_accum       <= n_accum;
            r_flags       <= n_flags;
            r_class_hold  <= n_class_hold;
            r_pend_left   <= n_pend_left;
            r_pend_valid  <= n_pend_valid;
            r_err_latched <= n_err_latched;
            r_out_valid   <= n_out_valid;
        end
    end

    // result payload: loaded only with a new result, held otherwise
    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_res <= n_res;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_kind         = r_res.kind;
    assign o_stmt_class   = r_res.stmt_class;
    assign o_stmt_type    = r_res.stmt_type;
    assign o_present      = r_res.present;
    assign o_input_flag   = r_res.input_flag;
    assign o_first_index  = r_res.first_index;
    assign o_second_index = r_res.second_index;
    assign o_error_code   = r_res.error_code;

endmodule

### src/ssd_checker.sv
// Port-level checker for the statement stream decoder, bound to the top level.
`include "statement_stream_decoder_assert.svh"

module ssd_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          o_in_stall,
    input logic                          o_out_valid,
    input logic                          i_out_stall,
    input logic [ssd_pkg::KIND_W-1:0]    o_kind,
    input logic [ssd_pkg::CLASS_W-1:0]   o_stmt_class,
    input logic [ssd_pkg::TYPE_W-1:0]    o_stmt_type,
    input logic [ssd_pkg::ID_W-1:0]      o_first_index,
    input logic [ssd_pkg::ID_W-1:0]      o_second_index
);
    import ssd_pkg::*;

    // a waiting result keeps its payload
    `SSD_ASSERT_NEXT(a_hold_stalled, o_out_valid && i_out_stall, o_out_valid && $stable(o_kind) && $stable(o_first_index) && $stable(o_second_index))

    // input is held back only by a waiting, stalled result
    `SSD_ASSERT_NOW(a_stall_cause, o_in_stall, o_out_valid && i_out_stall)

    // header fields are zero on every other kind of result
    `SSD_ASSERT_NOW(a_hdr_fields, o_out_valid && (o_kind != KIND_HEADER), (o_stmt_class == '0) && (o_stmt_type == '0))

    // nothing follows a delivered error until reset
    `SSD_ASSERT_NEXT(a_err_sticky, o_out_valid && !i_out_stall && (o_kind == KIND_ERROR), !o_out_valid)

endmodule

bind statement_stream_decoder ssd_checker u_ssd_checker (.*);
